// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker, soa_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SOA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define SOA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// File: rtl/soa_pkg.sv
// Types, codes and fixed command constants for the sonar rover sequencer.
// No dependencies.
package soa_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int THR_W     = 14;
	localparam int STEP_W    = 7;
	localparam int MS_W      = 10;
	localparam int PWM_W     = 8;
	localparam int DEG_W     = 8;
	localparam int ANGLE_W   = 9;
	localparam int SUM_W     = 17;
	localparam int MODE_W    = 3;
	localparam int KIND_W    = 2;
	localparam int NCMD      = 4;
	localparam int CNT_W     = 3;

	localparam logic [SUM_W-1:0] SUM_MAX = 17'd131071;
	localparam logic [ANGLE_W-1:0] ANGLE_MID = 9'd90;
	localparam logic [DEG_W-1:0] DEG_CENTER = 8'd90;
	localparam logic [DEG_W-1:0] DEG_ZERO = 8'd0;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_DIST      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_EXIT_DIST = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOO_CLOSE_DIST = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIGH     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP_DEG  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_WAIT   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_WAIT      = 4'd7;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_MOTOR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SERVO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WAIT  = 2'd2;

	// Reported mode codes
	localparam logic [MODE_W-1:0] MCODE_START   = 3'd0;
	localparam logic [MODE_W-1:0] MCODE_EXPLORE = 3'd1;
	localparam logic [MODE_W-1:0] MCODE_STOP    = 3'd2;
	localparam logic [MODE_W-1:0] MCODE_SCAN    = 3'd3;
	localparam logic [MODE_W-1:0] MCODE_TLEFT   = 3'd4;
	localparam logic [MODE_W-1:0] MCODE_TRIGHT  = 3'd5;
	localparam logic [MODE_W-1:0] MCODE_BACK    = 3'd6;
	localparam logic [MODE_W-1:0] MCODE_UNUSED  = 3'd7;

	// Fixed duty pairs
	localparam logic [PWM_W-1:0] PWM_ZERO     = 8'd0;
	localparam logic [PWM_W-1:0] PWM_F07_L    = 8'd178;
	localparam logic [PWM_W-1:0] PWM_F07_R    = 8'd165;
	localparam logic [PWM_W-1:0] PWM_F08_L    = 8'd204;
	localparam logic [PWM_W-1:0] PWM_F08_R    = 8'd188;
	localparam logic [PWM_W-1:0] PWM_B075_L   = 8'd191;
	localparam logic [PWM_W-1:0] PWM_B075_R   = 8'd181;
	localparam logic [PWM_W-1:0] PWM_B07_L    = 8'd178;
	localparam logic [PWM_W-1:0] PWM_B07_R    = 8'd169;
	localparam logic [PWM_W-1:0] PWM_SINGLE   = 8'd250;

	typedef enum logic [6:0] {
		MODE_START   = 7'b0000001,
		MODE_EXPLORE = 7'b0000010,
		MODE_STOP    = 7'b0000100,
		MODE_SCAN    = 7'b0001000,
		MODE_TLEFT   = 7'b0010000,
		MODE_TRIGHT  = 7'b0100000,
		MODE_BACK    = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              len;
		logic              lfwd;
		logic [PWM_W-1:0]  lpwm;
		logic              ren;
		logic              rfwd;
		logic [PWM_W-1:0]  rpwm;
		logic [DEG_W-1:0]  deg;
		logic [MS_W-1:0]   wt;
	} cmd_t;

	localparam cmd_t CMD_NONE = '0;

	function automatic cmd_t motor_cmd(logic fwd, logic [PWM_W-1:0] lp,
			logic [PWM_W-1:0] rp);
		cmd_t c;
		c = CMD_NONE;
		c.kind = KIND_MOTOR;
		c.len  = 1'b1;
		c.lfwd = fwd;
		c.lpwm = lp;
		c.ren  = 1'b1;
		c.rfwd = fwd;
		c.rpwm = rp;
		return c;
	endfunction

	function automatic cmd_t left_only_cmd();
		cmd_t c;
		c = CMD_NONE;
		c.kind = KIND_MOTOR;
		c.len  = 1'b1;
		c.lfwd = 1'b1;
		c.lpwm = PWM_SINGLE;
		return c;
	endfunction

	function automatic cmd_t right_only_cmd();
		cmd_t c;
		c = CMD_NONE;
		c.kind = KIND_MOTOR;
		c.ren  = 1'b1;
		c.rfwd = 1'b1;
		c.rpwm = PWM_SINGLE;
		return c;
	endfunction

	function automatic cmd_t servo_cmd(logic [DEG_W-1:0] deg);
		cmd_t c;
		c = CMD_NONE;
		c.kind = KIND_SERVO;
		c.deg  = deg;
		return c;
	endfunction

	function automatic cmd_t wait_cmd(logic [MS_W-1:0] ms);
		cmd_t c;
		c = CMD_NONE;
		c.kind = KIND_WAIT;
		c.wt   = ms;
		return c;
	endfunction

	function automatic logic [MODE_W-1:0] mode_code(mode_t m);
		logic [MODE_W-1:0] r;
		case (m)
			MODE_START:   r = MCODE_START;
			MODE_EXPLORE: r = MCODE_EXPLORE;
			MODE_STOP:    r = MCODE_STOP;
			MODE_SCAN:    r = MCODE_SCAN;
			MODE_TLEFT:   r = MCODE_TLEFT;
			MODE_TRIGHT:  r = MCODE_TRIGHT;
			MODE_BACK:    r = MCODE_BACK;
			default:      r = MCODE_UNUSED;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/sonar_obstacle_avoid_sequencer_top.sv
// Top level of the sonar rover sequencer: input register, step logic,
// command buffer and configuration registers. Depends on soa_pkg.
//
// Each accepted distance sample is registered, then the step logic updates
// the mode and scan state and loads zero to four commands into a four-entry
// command buffer, which presents one command per cycle while out_ready is
// high. A new sample is taken into the input register while the previous
// one's commands drain; it is loaded once the buffer is empty or its last
// command is transferring. The first command of a sample appears once the
// sample is loaded into the buffer. Configuration writes are taken every
// cycle.
module sonar_obstacle_avoid_sequencer_top
	import soa_pkg::*;
#(
	parameter int DIST_BITS      = 14,
	parameter int SCAN_LIMIT_DEG = 180
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DIST_BITS-1:0]  distance_mm,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     cmd_kind,
	output logic                  left_en,
	output logic                  left_fwd,
	output logic [PWM_W-1:0]      left_pwm,
	output logic                  right_en,
	output logic                  right_fwd,
	output logic [PWM_W-1:0]      right_pwm,
	output logic [DEG_W-1:0]      servo_deg,
	output logic [MS_W-1:0]       wait_ms,
	output logic [MODE_W-1:0]     mode_now,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [THR_W-1:0]      cfg_data
);

	localparam int CMP_W = (DIST_BITS > THR_W) ? DIST_BITS : THR_W;
	localparam int ADD_W = ((DIST_BITS > SUM_W) ? DIST_BITS : SUM_W) + 1;

	// Configuration
	logic [THR_W-1:0]  safe_dist_q, back_exit_q, too_close_q, start_low_q, start_high_q;
	logic [STEP_W-1:0] scan_step_q;
	logic [MS_W-1:0]   backoff_wait_q, turn_wait_q;

	// Input stage
	logic                 v_s1;
	logic [DIST_BITS-1:0] d_s1;

	// Sequencer state
	mode_t              mode_q, mode_d;
	logic               scan_begun_q, scan_begun_d;
	logic [ANGLE_W-1:0] scan_angle_q, scan_angle_d;
	logic [SUM_W-1:0]   lsum_q, lsum_d, rsum_q, rsum_d;

	// Command buffer
	cmd_t            buf_q [NCMD];
	cmd_t            buf_d [NCMD];
	logic [CNT_W-1:0] rem_q, n_d;

	logic                 load, xfer;
	logic [CMP_W-1:0]     dx;
	logic [ADD_W-1:0]     radd, ladd;
	logic [SUM_W-1:0]     rsat, lsat;
	logic [STEP_W-1:0]    step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_dist_q    <= 14'd150;
			back_exit_q    <= 14'd225;
			too_close_q    <= 14'd60;
			start_low_q    <= 14'd50;
			start_high_q   <= 14'd120;
			scan_step_q    <= 7'd15;
			backoff_wait_q <= 10'd300;
			turn_wait_q    <= 10'd300;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAFE_DIST:      safe_dist_q    <= cfg_data;
				REG_BACK_EXIT_DIST: back_exit_q    <= cfg_data;
				REG_TOO_CLOSE_DIST: too_close_q    <= cfg_data;
				REG_START_LOW:      start_low_q    <= cfg_data;
				REG_START_HIGH:     start_high_q   <= cfg_data;
				REG_SCAN_STEP_DEG:  scan_step_q    <= cfg_data[STEP_W-1:0];
				REG_BACKOFF_WAIT:   backoff_wait_q <= cfg_data[MS_W-1:0];
				REG_TURN_WAIT:      turn_wait_q    <= cfg_data[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_valid = (rem_q != '0);
	assign xfer      = out_valid && out_ready;
	assign load      = v_s1 && ((rem_q == '0) || (rem_q == CNT_W'(1) && out_ready));
	assign in_ready  = !v_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= distance_mm;
		end
	end

	assign dx   = CMP_W'(d_s1);
	assign step = (scan_step_q == '0) ? STEP_W'(1) : scan_step_q;
	assign radd = ADD_W'(rsum_q) + ADD_W'(d_s1);
	assign ladd = ADD_W'(lsum_q) + ADD_W'(d_s1);
	assign rsat = (radd > ADD_W'(SUM_MAX)) ? SUM_MAX : radd[SUM_W-1:0];
	assign lsat = (ladd > ADD_W'(SUM_MAX)) ? SUM_MAX : ladd[SUM_W-1:0];

	always_comb begin
		mode_d       = mode_q;
		scan_begun_d = scan_begun_q;
		scan_angle_d = scan_angle_q;
		lsum_d       = lsum_q;
		rsum_d       = rsum_q;
		n_d          = '0;
		for (int i = 0; i < NCMD; i++) begin
			buf_d[i] = CMD_NONE;
		end
		case (mode_q)
			MODE_EXPLORE: begin
				if (dx < CMP_W'(safe_dist_q)) begin
					buf_d[0] = motor_cmd(1'b0, PWM_ZERO, PWM_ZERO);
					n_d      = CNT_W'(1);
					mode_d   = MODE_STOP;
				end
			end
			MODE_BACK: begin
				if (dx > CMP_W'(back_exit_q)) begin
					buf_d[0] = motor_cmd(1'b0, PWM_ZERO, PWM_ZERO);
					n_d      = CNT_W'(1);
					mode_d   = MODE_STOP;
				end
			end
			MODE_STOP: begin
				if (dx < CMP_W'(too_close_q)) begin
					buf_d[0] = motor_cmd(1'b0, PWM_B075_L, PWM_B075_R);
					n_d      = CNT_W'(1);
					mode_d   = MODE_BACK;
				end else begin
					mode_d = MODE_SCAN;
				end
			end
			MODE_START: begin
				buf_d[0] = motor_cmd(1'b0, PWM_ZERO, PWM_ZERO);
				buf_d[1] = servo_cmd(DEG_CENTER);
				n_d      = CNT_W'(2);
				if (dx > CMP_W'(start_low_q) && dx < CMP_W'(start_high_q)) begin
					buf_d[2] = motor_cmd(1'b1, PWM_F07_L, PWM_F07_R);
					n_d      = CNT_W'(3);
					mode_d   = MODE_EXPLORE;
				end
			end
			MODE_SCAN: begin
				if (!scan_begun_q) begin
					buf_d[0]     = motor_cmd(1'b0, PWM_B07_L, PWM_B07_R);
					buf_d[1]     = wait_cmd(backoff_wait_q);
					buf_d[2]     = motor_cmd(1'b0, PWM_ZERO, PWM_ZERO);
					buf_d[3]     = servo_cmd(DEG_ZERO);
					n_d          = CNT_W'(4);
					scan_begun_d = 1'b1;
					scan_angle_d = '0;
				end else if (scan_angle_q <= ANGLE_W'(SCAN_LIMIT_DEG)) begin
					if (scan_angle_q < ANGLE_MID) begin
						rsum_d = rsat;
					end else begin
						lsum_d = lsat;
					end
					buf_d[0]     = servo_cmd(scan_angle_q[DEG_W-1:0]);
					n_d          = CNT_W'(1);
					scan_angle_d = scan_angle_q + ANGLE_W'(step);
				end else begin
					buf_d[0]     = servo_cmd(DEG_CENTER);
					n_d          = CNT_W'(1);
					mode_d       = (lsum_q > rsum_q) ? MODE_TLEFT : MODE_TRIGHT;
					lsum_d       = '0;
					rsum_d       = '0;
					scan_begun_d = 1'b0;
					scan_angle_d = '0;
				end
			end
			MODE_TLEFT: begin
				buf_d[0] = right_only_cmd();
				buf_d[1] = wait_cmd(turn_wait_q);
				buf_d[2] = motor_cmd(1'b1, PWM_F08_L, PWM_F08_R);
				n_d      = CNT_W'(3);
				mode_d   = MODE_EXPLORE;
			end
			MODE_TRIGHT: begin
				buf_d[0] = left_only_cmd();
				buf_d[1] = wait_cmd(turn_wait_q);
				buf_d[2] = motor_cmd(1'b1, PWM_F08_L, PWM_F08_R);
				n_d      = CNT_W'(3);
				mode_d   = MODE_EXPLORE;
			end
			default: begin
				buf_d[0] = motor_cmd(1'b0, PWM_ZERO, PWM_ZERO);
				n_d      = CNT_W'(1);
				mode_d   = MODE_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_START;
			scan_begun_q <= 1'b0;
			scan_angle_q <= '0;
			lsum_q       <= '0;
			rsum_q       <= '0;
			rem_q        <= '0;
		end else if (load) begin
			mode_q       <= mode_d;
			scan_begun_q <= scan_begun_d;
			scan_angle_q <= scan_angle_d;
			lsum_q       <= lsum_d;
			rsum_q       <= rsum_d;
			rem_q        <= n_d;
		end else if (xfer) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NCMD; i++) begin
				buf_q[i] <= buf_d[i];
			end
		end else if (xfer) begin
			for (int i = 0; i < NCMD - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[NCMD-1] <= CMD_NONE;
		end
	end

	assign cmd_kind  = buf_q[0].kind;
	assign left_en   = buf_q[0].len;
	assign left_fwd  = buf_q[0].lfwd;
	assign left_pwm  = buf_q[0].lpwm;
	assign right_en  = buf_q[0].ren;
	assign right_fwd = buf_q[0].rfwd;
	assign right_pwm = buf_q[0].rpwm;
	assign servo_deg = buf_q[0].deg;
	assign wait_ms   = buf_q[0].wt;
	assign mode_now  = mode_code(mode_q);
	assign last      = (rem_q == CNT_W'(1));

endmodule

// File: rtl/soa_checker.sv
// Port-level checker for the sonar rover sequencer, bound to the top level.
// Depends on soa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module soa_checker
	import soa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] cmd_kind,
	input logic [PWM_W-1:0]  left_pwm,
	input logic [PWM_W-1:0]  right_pwm,
	input logic              left_en,
	input logic              right_en,
	input logic [DEG_W-1:0]  servo_deg,
	input logic [MS_W-1:0]   wait_ms,
	input logic [MODE_W-1:0] mode_now,
	input logic              last
);

	`SOA_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(cmd_kind) && $stable(servo_deg) && $stable(wait_ms) && $stable(last))
	`SOA_ASSERT(a_more_follow, clk, arst_n, out_valid && out_ready && !last |=> out_valid && $stable(mode_now))
	`SOA_ASSERT(a_kind_fields, clk, arst_n, out_valid && cmd_kind != KIND_MOTOR |-> !left_en && !right_en && left_pwm == '0 && right_pwm == '0)
	`SOA_ASSERT(a_kind_code, clk, arst_n, out_valid |-> (cmd_kind == KIND_MOTOR || cmd_kind == KIND_SERVO || cmd_kind == KIND_WAIT) && mode_now != MCODE_UNUSED)
	`SOA_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid || arst_n)

endmodule

bind sonar_obstacle_avoid_sequencer_top soa_checker u_soa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.cmd_kind  (cmd_kind),
	.left_pwm  (left_pwm),
	.right_pwm (right_pwm),
	.left_en   (left_en),
	.right_en  (right_en),
	.servo_deg (servo_deg),
	.wait_ms   (wait_ms),
	.mode_now  (mode_now),
	.last      (last)
);

// File: tb/soa_cmd_checker.sv
// Checker for the sonar rover sequencer: watches the sample, command and register channels,
// predicts every command from its own rover model and compares field by field.
// Depends on soa_pkg.
`timescale 1ns / 1ps

module soa_cmd_checker
	import soa_pkg::*;
#(
	parameter int DIST_BITS      = 14,
	parameter int SCAN_LIMIT_DEG = 180
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [DIST_BITS-1:0] distance_mm,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [KIND_W-1:0]    cmd_kind,
	input  logic                 left_en,
	input  logic                 left_fwd,
	input  logic [PWM_W-1:0]     left_pwm,
	input  logic                 right_en,
	input  logic                 right_fwd,
	input  logic [PWM_W-1:0]     right_pwm,
	input  logic [DEG_W-1:0]     servo_deg,
	input  logic [MS_W-1:0]      wait_ms,
	input  logic [MODE_W-1:0]    mode_now,
	input  logic                 last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   cmds_due
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              len;
		logic              lfwd;
		logic [PWM_W-1:0]  lpwm;
		logic              ren;
		logic              rfwd;
		logic [PWM_W-1:0]  rpwm;
		logic [DEG_W-1:0]  deg;
		logic [MS_W-1:0]   wt;
		logic [MODE_W-1:0] mode;
		logic              last;
	} rover_cmd_t;

	// rover state
	logic [MODE_W-1:0]  rover_mode;
	logic               scan_on;
	logic [ANGLE_W-1:0] scan_pos;
	logic [SUM_W-1:0]   left_sum;
	logic [SUM_W-1:0]   right_sum;

	// register copies
	logic [THR_W-1:0]  safe_thr;
	logic [THR_W-1:0]  back_thr;
	logic [THR_W-1:0]  close_thr;
	logic [THR_W-1:0]  win_lo;
	logic [THR_W-1:0]  win_hi;
	logic [STEP_W-1:0] step_deg;
	logic [MS_W-1:0]   backoff_ms;
	logic [MS_W-1:0]   turn_ms;

	rover_cmd_t pending_cmds[$];
	rover_cmd_t step_cmds[$];
	rover_cmd_t seen_cmd;
	rover_cmd_t want_cmd;

	task automatic report(input string msg);
		mismatches++;
		$display("checker: %s at %0t ns", msg, $time);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic void add_cmd(logic [KIND_W-1:0] kind, logic len, logic lf,
			logic [PWM_W-1:0] lp, logic ren, logic rf, logic [PWM_W-1:0] rp,
			logic [DEG_W-1:0] deg, logic [MS_W-1:0] wt);
		rover_cmd_t c;
		c = '{kind, len, lf, lp, ren, rf, rp, deg, wt, MCODE_START, 1'b0};
		step_cmds.push_back(c);
	endfunction

	function automatic void drive_tracks(logic fwd, logic [PWM_W-1:0] lp, logic [PWM_W-1:0] rp);
		add_cmd(KIND_MOTOR, 1'b1, fwd, lp, 1'b1, fwd, rp, DEG_ZERO, '0);
	endfunction

	function automatic void aim_servo(logic [DEG_W-1:0] deg);
		add_cmd(KIND_SERVO, 1'b0, 1'b0, PWM_ZERO, 1'b0, 1'b0, PWM_ZERO, deg, '0);
	endfunction

	function automatic void hold_ms(logic [MS_W-1:0] ms);
		add_cmd(KIND_WAIT, 1'b0, 1'b0, PWM_ZERO, 1'b0, 1'b0, PWM_ZERO, DEG_ZERO, ms);
	endfunction

	function automatic logic [SUM_W-1:0] add_space(logic [SUM_W-1:0] s, logic [DIST_BITS-1:0] d);
		logic [31:0] t;
		t = 32'(s) + 32'(d);
		return (t > 32'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
	endfunction

	task automatic advance_rover(input logic [DIST_BITS-1:0] d);
		logic [ANGLE_W-1:0] inc;
		step_cmds.delete();
		case (rover_mode)
			MCODE_EXPLORE: begin
				if (d < safe_thr) begin
					drive_tracks(1'b0, PWM_ZERO, PWM_ZERO);
					rover_mode = MCODE_STOP;
				end
			end
			MCODE_BACK: begin
				if (d > back_thr) begin
					drive_tracks(1'b0, PWM_ZERO, PWM_ZERO);
					rover_mode = MCODE_STOP;
				end
			end
			MCODE_STOP: begin
				if (d < close_thr) begin
					drive_tracks(1'b0, PWM_B075_L, PWM_B075_R);
					rover_mode = MCODE_BACK;
				end else begin
					rover_mode = MCODE_SCAN;
				end
			end
			MCODE_START: begin
				drive_tracks(1'b0, PWM_ZERO, PWM_ZERO);
				aim_servo(DEG_CENTER);
				if (d > win_lo && d < win_hi) begin
					drive_tracks(1'b1, PWM_F07_L, PWM_F07_R);
					rover_mode = MCODE_EXPLORE;
				end
			end
			MCODE_SCAN: begin
				if (!scan_on) begin
					drive_tracks(1'b0, PWM_B07_L, PWM_B07_R);
					hold_ms(backoff_ms);
					drive_tracks(1'b0, PWM_ZERO, PWM_ZERO);
					aim_servo(DEG_ZERO);
					scan_on = 1'b1;
					scan_pos = '0;
				end else if (scan_pos <= SCAN_LIMIT_DEG) begin
					inc = (step_deg == '0) ? ANGLE_W'(1) : ANGLE_W'(step_deg);
					if (scan_pos < ANGLE_MID)
						right_sum = add_space(right_sum, d);
					else
						left_sum = add_space(left_sum, d);
					aim_servo(scan_pos[DEG_W-1:0]);
					scan_pos = scan_pos + inc;
				end else begin
					aim_servo(DEG_CENTER);
					rover_mode = (left_sum > right_sum) ? MCODE_TLEFT : MCODE_TRIGHT;
					left_sum = '0;
					right_sum = '0;
					scan_on = 1'b0;
					scan_pos = '0;
				end
			end
			MCODE_TLEFT: begin
				add_cmd(KIND_MOTOR, 1'b0, 1'b0, PWM_ZERO, 1'b1, 1'b1, PWM_SINGLE, DEG_ZERO, '0);
				hold_ms(turn_ms);
				drive_tracks(1'b1, PWM_F08_L, PWM_F08_R);
				rover_mode = MCODE_EXPLORE;
			end
			MCODE_TRIGHT: begin
				add_cmd(KIND_MOTOR, 1'b1, 1'b1, PWM_SINGLE, 1'b0, 1'b0, PWM_ZERO, DEG_ZERO, '0);
				hold_ms(turn_ms);
				drive_tracks(1'b1, PWM_F08_L, PWM_F08_R);
				rover_mode = MCODE_EXPLORE;
			end
			default: begin
				drive_tracks(1'b0, PWM_ZERO, PWM_ZERO);
				rover_mode = MCODE_START;
			end
		endcase
		foreach (step_cmds[k]) begin
			step_cmds[k].mode = rover_mode;
			step_cmds[k].last = (k == step_cmds.size() - 1);
			pending_cmds.push_back(step_cmds[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rover_mode = MCODE_START;
			scan_on = 1'b0;
			scan_pos = '0;
			left_sum = '0;
			right_sum = '0;
			safe_thr = 14'd150;
			back_thr = 14'd225;
			close_thr = 14'd60;
			win_lo = 14'd50;
			win_hi = 14'd120;
			step_deg = 7'd15;
			backoff_ms = 10'd300;
			turn_ms = 10'd300;
			pending_cmds.delete();
			mismatches = 0;
			cmds_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAFE_DIST:      safe_thr = cfg_data;
					REG_BACK_EXIT_DIST: back_thr = cfg_data;
					REG_TOO_CLOSE_DIST: close_thr = cfg_data;
					REG_START_LOW:      win_lo = cfg_data;
					REG_START_HIGH:     win_hi = cfg_data;
					REG_SCAN_STEP_DEG:  step_deg = cfg_data[STEP_W-1:0];
					REG_BACKOFF_WAIT:   backoff_ms = cfg_data[MS_W-1:0];
					REG_TURN_WAIT:      turn_ms = cfg_data[MS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				advance_rover(distance_mm);
			if (out_valid && out_ready) begin
				seen_cmd = '{cmd_kind, left_en, left_fwd, left_pwm, right_en, right_fwd,
					right_pwm, servo_deg, wait_ms, mode_now, last};
				if (pending_cmds.size() == 0) begin
					report("command transfer with nothing expected");
				end else begin
					want_cmd = pending_cmds.pop_front();
					check_field("cmd_kind", seen_cmd.kind, want_cmd.kind);
					check_field("left_en", seen_cmd.len, want_cmd.len);
					check_field("left_fwd", seen_cmd.lfwd, want_cmd.lfwd);
					check_field("left_pwm", seen_cmd.lpwm, want_cmd.lpwm);
					check_field("right_en", seen_cmd.ren, want_cmd.ren);
					check_field("right_fwd", seen_cmd.rfwd, want_cmd.rfwd);
					check_field("right_pwm", seen_cmd.rpwm, want_cmd.rpwm);
					check_field("servo_deg", seen_cmd.deg, want_cmd.deg);
					check_field("wait_ms", seen_cmd.wt, want_cmd.wt);
					check_field("mode_now", seen_cmd.mode, want_cmd.mode);
					check_field("last", seen_cmd.last, want_cmd.last);
				end
			end
			cmds_due <= pending_cmds.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the sonar rover sequencer testbench: clock, reset, register writes, sample
// stimulus with bursts and gaps, command-side stalls and the verdict.
// Depends on soa_pkg, sonar_obstacle_avoid_sequencer_top and soa_cmd_checker.
`timescale 1ns / 1ps

module tb_top;
	import soa_pkg::*;

	localparam int DIST_BITS = 14;
	localparam int DIST_MAX  = (1 << DIST_BITS) - 1;
	localparam int SETTLE    = 12;
	localparam int LONG_HOLD = 300;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [DIST_BITS-1:0] distance_mm;
	logic                 out_valid;
	logic                 out_ready;
	logic [KIND_W-1:0]    cmd_kind;
	logic                 left_en;
	logic                 left_fwd;
	logic [PWM_W-1:0]     left_pwm;
	logic                 right_en;
	logic                 right_fwd;
	logic [PWM_W-1:0]     right_pwm;
	logic [DEG_W-1:0]     servo_deg;
	logic [MS_W-1:0]      wait_ms;
	logic [MODE_W-1:0]    mode_now;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	int                   mismatches;
	int                   cmds_due;

	logic [THR_W-1:0]     reg_val [8];
	logic [DIST_BITS-1:0] scripted[$];
	bit                   hold_req;

	sonar_obstacle_avoid_sequencer_top uut (.*);

	soa_cmd_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// command side: changing stall styles, plus a long hold on request
	initial begin
		bit hold_seen;
		int cyc;
		int style;
		hold_seen = 1'b0;
		cyc = 0;
		style = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 48 == 0)
				style = $urandom_range(0, 3);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (cyc % 5 < 3);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [DIST_BITS-1:0] pick_distance();
		int r;
		int t;
		r = $urandom_range(0, 99);
		if (r < 25)
			t = int'(reg_val[$urandom_range(REG_SAFE_DIST, REG_START_HIGH)])
				+ int'($urandom_range(0, 2)) - 1;
		else if (r < 55)
			t = $urandom_range(0, 300);
		else if (r < 70)
			t = $urandom_range(0, DIST_MAX);
		else if (r < 80)
			t = $urandom_range(0, 1) ? DIST_MAX : 0;
		else
			t = $urandom_range(0, 1000);
		if (t < 0)
			t = 0;
		if (t > DIST_MAX)
			t = DIST_MAX;
		return t[DIST_BITS-1:0];
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (cmds_due != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input int safe, input int back_exit, input int too_close,
			input int lo, input int hi, input int step, input int backoff, input int turn,
			input bit add_bogus);
		logic [CFG_IDX_W-1:0] idx;
		reg_val[REG_SAFE_DIST] = THR_W'(safe);
		reg_val[REG_BACK_EXIT_DIST] = THR_W'(back_exit);
		reg_val[REG_TOO_CLOSE_DIST] = THR_W'(too_close);
		reg_val[REG_START_LOW] = THR_W'(lo);
		reg_val[REG_START_HIGH] = THR_W'(hi);
		reg_val[REG_SCAN_STEP_DEG] = THR_W'(step);
		reg_val[REG_BACKOFF_WAIT] = THR_W'(backoff);
		reg_val[REG_TURN_WAIT] = THR_W'(turn);
		for (idx = REG_SAFE_DIST; idx <= REG_TURN_WAIT; idx++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= reg_val[idx];
			do @(posedge clk); while (!cfg_ready);
		end
		if (add_bogus) begin
			cfg_index <= REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 7));
			cfg_data <= THR_W'($urandom_range(0, DIST_MAX));
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [DIST_BITS-1:0] d);
		in_valid <= 1'b1;
		distance_mm <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drive_samples(input int count, input bit pressure);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && sent < count) begin
				if (pressure && sent == 20)
					hold_req <= ~hold_req;
				if (pressure && sent == 45) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				send_sample((scripted.size() != 0) ? scripted.pop_front() : pick_distance());
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		distance_mm = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SAFE_DIST;
		cfg_data = '0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk through every mode; 90 degree step keeps each scan short
		set_regs(150, 225, 60, 50, 120, 90, 300, 300, 1'b0);
		scripted = '{
			0, 50, 120, 51,            // start window edges, then explore
			150, 149,                  // explore holds at the threshold, then stop
			59, 225, 16383,            // stop reverses, back holds, back exits
			60, 5000,                  // stop to scan, scan begins
			0, 16383, 16383, 7,        // samples at 0, 90, 180, then left wins
			9,                         // turn left
			0, 60, 1, 0, 0, 0, 0,      // equal sums turn right
			0                          // turn right
		};
		drive_samples(scripted.size(), 1'b0);
		wait_drained();

		// reset values, long output hold and a full drain mid-stream
		set_regs(150, 225, 60, 50, 120, 15, 300, 300, 1'b1);
		drive_samples(70, 1'b1);
		wait_drained();

		// threshold extremes
		set_regs(DIST_MAX, 0, DIST_MAX, 0, DIST_MAX, 90, 1023, 1023, 1'b0);
		drive_samples(50, 1'b0);
		wait_drained();

		// zero step acts as one degree: long scans that saturate the sums
		set_regs(DIST_MAX, 0, 0, 0, 200, 0, 0, 0, 1'b1);
		drive_samples(190, 1'b0);
		wait_drained();

		// widest step the register holds
		set_regs(300, 1000, 100, 10, 16000, 127, 512, 1, 1'b0);
		drive_samples(30, 1'b0);
		wait_drained();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
